[design/sva_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sva_pkg - shared types and constants of the voice allocator
// widths, opcodes, status codes and the per-channel evaluation record
// ----------------------------------------------------------------------------
package sva_pkg;

  localparam int NUM_CHANNELS = 24;
  localparam int NUM_SAMPLES  = 64;

  localparam int CH_W    = $clog2(NUM_CHANNELS);
  localparam int SMP_W   = $clog2(NUM_SAMPLES);
  localparam int LEN_W   = 20;
  localparam int VOL_W   = 8;
  localparam int ADV_W   = 12;
  localparam int MV_W    = 7;
  localparam int SCORE_W = LEN_W + 1;

  // volume scaling (v*m+50)/100, divide by reciprocal multiply
  localparam int               PROD_W      = VOL_W + MV_W;
  localparam int               RECIP_W     = 13;
  localparam int               RECIP_SHIFT = 19;
  localparam int               FULL_W      = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP     = 13'd5243;
  localparam logic [PROD_W-1:0]  ROUND_ADD = 15'd50;
  localparam logic [MV_W-1:0]    MV_MAX    = 7'd100;

  // opcodes
  localparam logic [1:0] OP_PLAY    = 2'd0;
  localparam logic [1:0] OP_FRAME   = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;
  localparam logic [1:0] OP_STOP    = 2'd3;

  // result status codes
  localparam logic [2:0] ST_STARTED    = 3'd0;
  localparam logic [2:0] ST_NOT_LOADED = 3'd1;
  localparam logic [2:0] ST_SILENT     = 3'd2;
  localparam logic [2:0] ST_DUPLICATE  = 3'd3;
  localparam logic [2:0] ST_OTHER      = 3'd4;

  typedef struct packed {
    logic               free;      // inactive or at its end
    logic [LEN_W-1:0]   remain;    // bytes left
    logic [SCORE_W-1:0] score;     // remain + volume*256
    logic               adv_done;  // advance reaches the end
    logic [LEN_W-1:0]   pos_next;  // position after an advance
  } chan_eval_t;

endpackage
`default_nettype wire

[design/sva_chan_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sva_chan_unit - shared channel evaluation datapath
// one subtract/compare/add unit, reused for each channel during a scan
// ----------------------------------------------------------------------------
module sva_chan_unit
  import sva_pkg::*;
(
  input  wire logic             active,
  input  wire logic [LEN_W-1:0] length,
  input  wire logic [LEN_W-1:0] position,
  input  wire logic [VOL_W-1:0] volume,
  input  wire logic [ADV_W-1:0] adv,
  output chan_eval_t            eval
);

  logic [LEN_W:0] diff;
  logic           at_end;

  assign diff   = {1'b0, length} - {1'b0, position};
  // borrow or zero difference means position >= length
  assign at_end = diff[LEN_W] | (diff[LEN_W-1:0] == '0);

  always_comb begin
    eval.free     = !active || at_end;
    eval.remain   = diff[LEN_W-1:0];
    eval.score    = SCORE_W'(diff[LEN_W-1:0]) + SCORE_W'({volume, 8'h00});
    eval.adv_done = LEN_W'(adv) >= diff[LEN_W-1:0];
    eval.pos_next = eval.adv_done ? length : position + LEN_W'(adv);
  end

endmodule
`default_nettype wire

[design/sound_voice_allocator_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sound_voice_allocator_unit - voice allocator with voice stealing
// takes play / frame / advance / stop beats and answers each with one beat
// ----------------------------------------------------------------------------
// One operation is in flight at a time; in_stall is high from the accepting
// edge until the result has been handed to the output register. The cost is
// set by the channel scan, which walks the 24 channels one per cycle through
// a single shared evaluation unit. A play request passes accept, volume
// multiply, reciprocal divide and checks before the scan, which stops at the
// first free channel or steals after the last, then hands off. A rejected,
// silent or duplicate play skips the scan. An advance scans every channel.
// Frame tick and stop go straight to the hand-off. The hand-off waits while
// a previous result is still stalled at the output. The per-sample dedupe
// store is a flag per sample cleared at once on every frame tick, so no
// clearing pass exists. master_volume is to be written through
// cfg_valid/cfg_ready only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module sound_voice_allocator_unit
  import sva_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  // configuration
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [MV_W-1:0]  cfg_master_volume,
  // request channel
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       in_opcode,
  input  wire logic [5:0]       in_sample_index,
  input  wire logic [7:0]       in_request_volume,
  input  wire logic             in_sample_loaded,
  input  wire logic [19:0]      in_sample_length,
  input  wire logic [11:0]      in_advance_bytes,
  // result channel
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [2:0]            out_status,
  output logic [4:0]            out_channel_index,
  output logic                  out_was_stolen,
  output logic [7:0]            out_scaled_volume
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCALE = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_PICK  = 3'd4;
  localparam logic [2:0] S_ADV   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

  // control state
  logic [2:0]             state_r, state_nxt;
  logic [CH_W-1:0]        idx_r, idx_nxt;
  logic [NUM_CHANNELS-1:0] active_r, active_nxt;
  logic [NUM_SAMPLES-1:0] started_r, started_nxt;   // sample started this frame
  logic                   frame_on_r, frame_on_nxt; // frame id nonzero
  logic [MV_W-1:0]        mv_r;
  logic                   out_valid_r, out_valid_nxt;

  // channel store, one read and one write address per cycle
  logic [LEN_W-1:0] len_r [NUM_CHANNELS];
  logic [LEN_W-1:0] pos_r [NUM_CHANNELS];
  logic [VOL_W-1:0] vol_r [NUM_CHANNELS];

  logic             wr_en;
  logic [CH_W-1:0]  wr_idx;
  logic [LEN_W-1:0] wr_len;
  logic [LEN_W-1:0] wr_pos;
  logic [VOL_W-1:0] wr_vol;

  // captured request
  logic [SMP_W-1:0] sidx_q_r, sidx_q_nxt;
  logic [VOL_W-1:0] rvol_q_r, rvol_q_nxt;
  logic [LEN_W-1:0] slen_q_r, slen_q_nxt;
  logic [ADV_W-1:0] adv_q_r, adv_q_nxt;

  // arithmetic and scan registers
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  logic [VOL_W-1:0]   svol_r, svol_nxt;
  logic [SCORE_W-1:0] best_score_r, best_score_nxt;
  logic [CH_W-1:0]    best_idx_r, best_idx_nxt;

  // pending result
  logic [2:0]       res_status_r, res_status_nxt;
  logic [CH_W-1:0]  res_chan_r, res_chan_nxt;
  logic             res_stolen_r, res_stolen_nxt;
  logic [VOL_W-1:0] res_vol_r, res_vol_nxt;

  // output register
  logic [2:0]       out_status_r;
  logic [CH_W-1:0]  out_chan_r;
  logic             out_stolen_r;
  logic [VOL_W-1:0] out_vol_r;

  logic [MV_W-1:0]   mv_eff;
  logic [FULL_W-1:0] quot_full;
  logic              in_accept;
  logic              sample_ok;
  logic              better;
  chan_eval_t        eval;

  // master volume above 100 counts as 100
  assign mv_eff    = (mv_r > MV_MAX) ? MV_MAX : mv_r;
  assign quot_full = FULL_W'(prod_r) * FULL_W'(RECIP);
  assign sample_ok = 32'(in_sample_index) < NUM_SAMPLES;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_channel_index = 5'(out_chan_r);
  assign out_was_stolen    = out_stolen_r;
  assign out_scaled_volume = out_vol_r;

  // shared per-channel unit, fed from the scan index
  sva_chan_unit u_chan (
    .active   (active_r[idx_r]),
    .length   (len_r[idx_r]),
    .position (pos_r[idx_r]),
    .volume   (vol_r[idx_r]),
    .adv      (adv_q_r),
    .eval     (eval)
  );

  // strict compare keeps the lowest index on ties
  assign better = eval.score < best_score_r;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    active_nxt     = active_r;
    started_nxt    = started_r;
    frame_on_nxt   = frame_on_r;
    sidx_q_nxt     = sidx_q_r;
    rvol_q_nxt     = rvol_q_r;
    slen_q_nxt     = slen_q_r;
    adv_q_nxt      = adv_q_r;
    prod_nxt       = prod_r;
    svol_nxt       = svol_r;
    best_score_nxt = best_score_r;
    best_idx_nxt   = best_idx_r;
    res_status_nxt = res_status_r;
    res_chan_nxt   = res_chan_r;
    res_stolen_nxt = res_stolen_r;
    res_vol_nxt    = res_vol_r;
    wr_en          = 1'b0;
    wr_idx         = idx_r;
    wr_len         = slen_q_r;
    wr_pos         = '0;
    wr_vol         = svol_r;
    out_valid_nxt  = out_valid_r && out_stall;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          sidx_q_nxt     = in_sample_index;
          rvol_q_nxt     = in_request_volume;
          slen_q_nxt     = in_sample_length;
          adv_q_nxt      = in_advance_bytes;
          idx_nxt        = '0;
          best_score_nxt = '1;
          best_idx_nxt   = '0;
          res_status_nxt = ST_OTHER;
          res_chan_nxt   = '0;
          res_stolen_nxt = 1'b0;
          res_vol_nxt    = '0;
          case (in_opcode)
            OP_PLAY: begin
              if (!in_sample_loaded || !sample_ok) begin
                res_status_nxt = ST_NOT_LOADED;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_SCALE;
              end
            end
            OP_FRAME: begin
              // every frame (and the id wrap) starts with an empty table
              started_nxt  = '0;
              frame_on_nxt = 1'b1;
              state_nxt    = S_DONE;
            end
            OP_ADVANCE: begin
              state_nxt = S_ADV;
            end
            default: begin
              // stop all; position of an idle channel is never looked at
              active_nxt = '0;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end
      S_SCALE: begin
        prod_nxt  = PROD_W'(rvol_q_r) * PROD_W'(mv_eff) + ROUND_ADD;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        svol_nxt  = quot_full[RECIP_SHIFT +: VOL_W];
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (mv_eff == '0 || svol_r == '0) begin
          res_status_nxt = ST_SILENT;
          state_nxt      = S_DONE;
        end else if (frame_on_r && started_r[sidx_q_r]) begin
          res_status_nxt = ST_DUPLICATE;
          state_nxt      = S_DONE;
        end else begin
          if (frame_on_r) begin
            started_nxt[sidx_q_r] = 1'b1;
          end
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        if (eval.free || idx_r == LAST_CH) begin
          wr_en  = 1'b1;
          wr_idx = (eval.free || better) ? idx_r : best_idx_r;
          active_nxt[wr_idx] = 1'b1;
          res_status_nxt = ST_STARTED;
          res_chan_nxt   = wr_idx;
          res_stolen_nxt = !eval.free;
          res_vol_nxt    = svol_r;
          state_nxt      = S_DONE;
        end else begin
          if (better) begin
            best_score_nxt = eval.score;
            best_idx_nxt   = idx_r;
          end
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_ADV: begin
        if (!eval.free) begin
          wr_en  = 1'b1;
          wr_len = len_r[idx_r];
          wr_pos = eval.pos_next;
          wr_vol = vol_r[idx_r];
          if (eval.adv_done) begin
            active_nxt[idx_r] = 1'b0;
          end
        end
        if (idx_r == LAST_CH) begin
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      active_r    <= '0;
      started_r   <= '0;
      frame_on_r  <= 1'b0;
      mv_r        <= MV_MAX;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      active_r    <= active_nxt;
      started_r   <= started_nxt;
      frame_on_r  <= frame_on_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        mv_r <= cfg_master_volume;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sidx_q_r     <= sidx_q_nxt;
    rvol_q_r     <= rvol_q_nxt;
    slen_q_r     <= slen_q_nxt;
    adv_q_r      <= adv_q_nxt;
    prod_r       <= prod_nxt;
    svol_r       <= svol_nxt;
    best_score_r <= best_score_nxt;
    best_idx_r   <= best_idx_nxt;
    res_status_r <= res_status_nxt;
    res_chan_r   <= res_chan_nxt;
    res_stolen_r <= res_stolen_nxt;
    res_vol_r    <= res_vol_nxt;
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_status_r <= res_status_r;
      out_chan_r   <= res_chan_r;
      out_stolen_r <= res_stolen_r;
      out_vol_r    <= res_vol_r;
    end
    if (wr_en) begin
      len_r[wr_idx] <= wr_len;
      pos_r[wr_idx] <= wr_pos;
      vol_r[wr_idx] <= wr_vol;
    end
  end

  // a started beat always carries a nonzero volume and a real channel
  a_started_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_STARTED) |->
      (out_scaled_volume != '0 && 32'(out_channel_index) < NUM_CHANNELS))
    else $error("started beat with zero volume or bad channel");

  // any other status reports no channel, no steal, no volume
  a_other_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_STARTED) |->
      (out_channel_index == '0 && !out_was_stolen && out_scaled_volume == '0))
    else $error("non-start beat carries channel data");

  // a stop beat leaves every channel idle
  a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_opcode == OP_STOP) |=> (active_r == '0))
    else $error("stop left a channel active");

  // a frame tick empties the dedupe table and enables it
  a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_opcode == OP_FRAME) |=> (started_r == '0 && frame_on_r))
    else $error("frame tick did not reset dedupe table");

  // the started channel is active when its beat is first shown
  a_start_active: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid) && out_status == ST_STARTED) |->
      active_r[out_chan_r])
    else $error("started channel not active");

endmodule
`default_nettype wire

[verif/tb_sound_voice_allocator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sound_voice_allocator_unit - self-checking bench for the voice allocator
// drives play / frame / advance / stop beats with random gaps and output
// stalls, tracks the channel table in a scoreboard and checks every answer
// beat field by field, across several master volume settings
// ----------------------------------------------------------------------------
module tb_sound_voice_allocator_unit
  import sva_pkg::*;
();

  localparam int QUIET_LIMIT  = 4000;  // cycles with no handshake at all
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
  localparam int HOLD_AT      = 300;   // input beats accepted before the hold-off
  localparam int SETTLE       = 40;    // longer than the slowest operation
  localparam int IDLE_PCT     = 23;

  typedef struct {
    logic [1:0]       op;
    logic [SMP_W-1:0] sidx;
    logic [VOL_W-1:0] vol;
    logic             loaded;
    logic [LEN_W-1:0] len;
    logic [ADV_W-1:0] adv;
  } request_t;

  typedef struct {
    logic [2:0]       status;
    logic [4:0]       chan;
    logic             stolen;
    logic [VOL_W-1:0] vol;
  } answer_t;

  // mirror of the channel table and dedupe store; predicts one answer per beat
  class voice_allocation_tracker;
    bit               chan_busy[NUM_CHANNELS];
    logic [LEN_W-1:0] chan_len[NUM_CHANNELS];
    logic [LEN_W-1:0] chan_pos[NUM_CHANNELS];
    logic [VOL_W-1:0] chan_vol[NUM_CHANNELS];
    logic [31:0]      frame_id;
    logic [31:0]      sample_frame[NUM_SAMPLES];
    logic [MV_W-1:0]  master_pct;
    answer_t          pending_answers[$];
    int               errors;

    function new();
      foreach (chan_busy[c]) begin
        chan_busy[c] = 1'b0;
        chan_len[c]  = '0;
        chan_pos[c]  = '0;
        chan_vol[c]  = '0;
      end
      foreach (sample_frame[s]) sample_frame[s] = '0;
      frame_id   = '0;
      master_pct = MV_MAX;
      errors     = 0;
    endfunction

    function void set_master(logic [MV_W-1:0] pct);
      master_pct = pct;
    endfunction

    function int pending();
      return pending_answers.size();
    endfunction

    // first free channel, else the busy one with the lowest score
    function int pick_channel(output bit stolen);
      int best;
      int best_score;
      int score;
      best       = 0;
      best_score = 32'h7FFF_FFFF;
      stolen     = 1'b0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        if (!chan_busy[c] || chan_pos[c] >= chan_len[c]) return c;
        score = int'(chan_len[c] - chan_pos[c]) + (int'(chan_vol[c]) << 8);
        if (score < best_score) begin
          best_score = score;
          best       = c;
        end
      end
      stolen = 1'b1;
      return best;
    endfunction

    function void note_request(request_t r);
      answer_t a;
      int      pct;
      int      scaled;
      int      ch;
      bit      stolen;
      int      remain;
      int      take;
      a = '{ST_OTHER, 5'd0, 1'b0, '0};
      case (r.op)
        OP_PLAY: begin
          pct    = (master_pct > MV_MAX) ? int'(MV_MAX) : int'(master_pct);
          scaled = (int'(r.vol) * pct + 50) / 100;
          if (!r.loaded || int'(r.sidx) >= NUM_SAMPLES) begin
            a.status = ST_NOT_LOADED;
          end else if (pct == 0 || scaled == 0) begin
            a.status = ST_SILENT;
          end else if (frame_id != 0 && sample_frame[r.sidx] == frame_id) begin
            a.status = ST_DUPLICATE;
          end else begin
            if (frame_id != 0) sample_frame[r.sidx] = frame_id;
            ch            = pick_channel(stolen);
            chan_busy[ch] = 1'b1;
            chan_len[ch]  = r.len;
            chan_pos[ch]  = '0;
            chan_vol[ch]  = scaled[VOL_W-1:0];
            a = '{ST_STARTED, ch[4:0], stolen, scaled[VOL_W-1:0]};
          end
        end
        OP_FRAME: begin
          frame_id++;
          // wrap clears the dedupe store and restarts at one
          if (frame_id == 0) begin
            foreach (sample_frame[s]) sample_frame[s] = '0;
            frame_id = 1;
          end
        end
        OP_ADVANCE: begin
          for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (chan_busy[c] && chan_pos[c] < chan_len[c]) begin
              remain      = int'(chan_len[c] - chan_pos[c]);
              take        = (int'(r.adv) < remain) ? int'(r.adv) : remain;
              chan_pos[c] = chan_pos[c] + take[LEN_W-1:0];
              if (chan_pos[c] >= chan_len[c]) chan_busy[c] = 1'b0;
            end
          end
        end
        default: begin
          // stop keeps length and volume
          foreach (chan_busy[c]) begin
            chan_busy[c] = 1'b0;
            chan_pos[c]  = '0;
          end
        end
      endcase
      pending_answers.push_back(a);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_answer(answer_t got);
      answer_t want;
      if (pending_answers.size() == 0) begin
        $error("answer beat with nothing outstanding: status %0d", got.status);
        errors++;
        return;
      end
      want = pending_answers.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("channel_index", 32'(want.chan), 32'(got.chan));
      compare_field("was_stolen", 32'(want.stolen), 32'(got.stolen));
      compare_field("scaled_volume", 32'(want.vol), 32'(got.vol));
    endfunction
  endclass

  logic             clk;
  logic             rst_n             = 1'b0;
  logic             cfg_valid         = 1'b0;
  logic             cfg_ready;
  logic [MV_W-1:0]  cfg_master_volume = MV_MAX;
  logic             in_valid          = 1'b0;
  logic             in_stall;
  logic [1:0]       in_opcode         = OP_STOP;
  logic [5:0]       in_sample_index   = '0;
  logic [7:0]       in_request_volume = '0;
  logic             in_sample_loaded  = 1'b0;
  logic [19:0]      in_sample_length  = '0;
  logic [11:0]      in_advance_bytes  = '0;
  logic             out_valid;
  logic             out_stall         = 1'b0;
  logic [2:0]       out_status;
  logic [4:0]       out_channel_index;
  logic             out_was_stolen;
  logic [7:0]       out_scaled_volume;

  voice_allocation_tracker tracker = new();
  int   accepted_items = 0;
  logic calm;

  // a stretch of the run with no gaps and no stalls on either side
  assign calm = (accepted_items >= 500) && (accepted_items < 650);

  sound_voice_allocator_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_master_volume (cfg_master_volume),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_sample_index   (in_sample_index),
    .in_request_volume (in_request_volume),
    .in_sample_loaded  (in_sample_loaded),
    .in_sample_length  (in_sample_length),
    .in_advance_bytes  (in_advance_bytes),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_channel_index (out_channel_index),
    .out_was_stolen    (out_was_stolen),
    .out_scaled_volume (out_scaled_volume)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // one beat on the request channel, after a random number of idle cycles
  task automatic issue_request(input request_t r);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_opcode         <= r.op;
    in_sample_index   <= r.sidx;
    in_request_volume <= r.vol;
    in_sample_loaded  <= r.loaded;
    in_sample_length  <= r.len;
    in_advance_bytes  <= r.adv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(r);
    accepted_items++;
  endtask

  task automatic send_op(input logic [1:0] op, input int sidx, input int vol,
                         input bit loaded, input int len, input int adv);
    request_t r;
    r = '{op, sidx[SMP_W-1:0], vol[VOL_W-1:0], loaded, len[LEN_W-1:0], adv[ADV_W-1:0]};
    issue_request(r);
  endtask

  // mostly plays on long samples so the table fills and stealing kicks in;
  // half the plays reuse a small pool of samples to hit the dedupe check
  function automatic request_t random_request();
    request_t r;
    int       pick;
    pick     = $urandom_range(99);
    r.op     = (pick < 62) ? OP_PLAY : (pick < 76) ? OP_FRAME :
               (pick < 98) ? OP_ADVANCE : OP_STOP;
    r.sidx   = $urandom_range(1) ? SMP_W'($urandom_range(7)) : SMP_W'($urandom_range(63));
    pick     = $urandom_range(99);
    r.vol    = (pick < 10) ? '0 : (pick < 25) ? VOL_W'($urandom_range(3)) :
               VOL_W'($urandom_range(255));
    r.loaded = ($urandom_range(99) < 92);
    pick     = $urandom_range(99);
    r.len    = (pick < 5)  ? '0 :
               (pick < 20) ? LEN_W'($urandom_range(64)) :
               (pick < 30) ? {LEN_W{1'b1}} : LEN_W'($urandom_range(20'hFFFFF));
    pick     = $urandom_range(99);
    r.adv    = (pick < 10) ? '0 : (pick < 20) ? {ADV_W{1'b1}} :
               ADV_W'($urandom_range(12'hFFF));
    return r;
  endfunction

  // master volume is only written with nothing in flight
  task automatic write_master(input logic [MV_W-1:0] pct);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid         <= 1'b1;
    cfg_master_volume <= pct;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tracker.set_master(pct);
  endtask

  task automatic run_phase(input logic [MV_W-1:0] pct, input int beats);
    write_master(pct);
    repeat (beats) issue_request(random_request());
    in_valid <= 1'b0;
  endtask

  // answer side: random stalls plus one long hold-off while requests keep coming
  initial begin
    int  hold_left;
    bit  hold_used;
    hold_left = 0;
    hold_used = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        tracker.check_answer('{out_status, out_channel_index, out_was_stolen,
                               out_scaled_volume});
      if (!hold_used && accepted_items >= HOLD_AT) begin
        hold_used = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset master volume, frame id still zero
    send_op(OP_PLAY, 0, 200, 1'b0, 100, 0);           // sample not loaded
    send_op(OP_PLAY, 1, 0, 1'b1, 100, 0);             // silent
    send_op(OP_PLAY, 63, 255, 1'b1, 20'hFFFFF, 0);    // first free channel
    send_op(OP_PLAY, 63, 255, 1'b1, 20'hFFFFF, 0);    // no dedupe at frame zero
    send_op(OP_PLAY, 5, 1, 1'b1, 0, 0);               // zero length sample
    send_op(OP_PLAY, 6, 100, 1'b1, 1000, 0);          // reuses the zero length one
    send_op(OP_ADVANCE, 33, 17, 1'b1, 5, 0);          // advance by nothing
    send_op(OP_FRAME, 63, 255, 1'b0, 20'hFFFFF, 12'hFFF);
    send_op(OP_PLAY, 10, 128, 1'b1, 3000, 0);
    send_op(OP_PLAY, 10, 90, 1'b1, 3000, 0);          // duplicate in this frame
    send_op(OP_PLAY, 11, 1, 1'b1, 50, 0);
    send_op(OP_ADVANCE, 0, 0, 1'b0, 0, 12'hFFF);      // several channels run out
    send_op(OP_ADVANCE, 0, 0, 1'b0, 0, 0);
    send_op(OP_FRAME, 0, 0, 1'b0, 0, 0);
    send_op(OP_PLAY, 10, 77, 1'b1, 1, 0);             // allowed again in new frame
    send_op(OP_STOP, 42, 3, 1'b1, 777, 12'hABC);
    send_op(OP_PLAY, 12, 255, 1'b1, 20'hFFFFF, 12'hFFF);
    send_op(OP_PLAY, 13, 2, 1'b1, 2, 0);
    in_valid <= 1'b0;

    // random part over several master settings, extremes included
    run_phase(7'd0, 60);                              // every play silent
    run_phase(7'd127, 250);                           // above range, acts as full
    run_phase(7'd1, 120);                             // rounding edge
    run_phase(MV_MAX, 250);
    run_phase(MV_W'($urandom_range(2, 99)), 250);

    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (tracker.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[sim.f]
design/sva_pkg.sv
design/sva_chan_unit.sv
design/sound_voice_allocator_unit.sv
verif/tb_sound_voice_allocator_unit.sv
